FILE: rtl/core/pdst_pkg.sv
// shared types and constants for the per-device send throttle
`timescale 1ns / 1ps

package pdst_pkg;

    // field widths of the stream words
    localparam int REQ_W      = 2;
    localparam int DEV_ID_W   = 8;
    localparam int IFACE_W    = 2;
    localparam int LIMIT_W    = 8;
    localparam int COUNT_W    = 8;
    localparam int PLEN_W     = 16;
    localparam int SP_W       = 16;
    localparam int TICKS_W    = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    // interfaces that a learn may name
    localparam int NUM_IFACES = 4;

    // divider: 17-bit dividend covers phase + 1, 16-bit divisor
    localparam int DIV_W = 17;
    localparam int DVS_W = 16;

    localparam logic [SP_W-1:0]    SCHED_PERIOD_RST = 16'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 8'hFF;

    // request kinds carried in tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_SEND  = 2'd1,
        REQ_LEARN = 2'd2,
        REQ_SET   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_DONE,
        ST_SW_RD,
        ST_SW_EX,
        ST_SW_DIV
    } t_state;

    // one device entry of the state memory
    typedef struct packed {
        logic                 mark;
        logic                 route_valid;
        logic [IFACE_W-1:0]   route_iface;
        logic [LIMIT_W-1:0]   limit;
        logic [COUNT_W-1:0]   count;
        logic [TICKS_W-1:0]   period;
        logic [TICKS_W-1:0]   phase;
    } t_entry;

    // latched input word
    typedef struct packed {
        t_req                req;
        logic [DEV_ID_W-1:0] dev;
        logic [IFACE_W-1:0]  iface;
        logic [LIMIT_W-1:0]  limit;
        logic [PLEN_W-1:0]   plen;
    } t_item;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic rd_input;
        logic rd_sweep;
        logic wr_item;
        logic wr_sweep;
        logic wr_clear;
        logic div_start;
        logic div_mod;
        logic idx_clr;
        logic idx_inc;
        logic push;
        logic wake_clr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_req req;
        logic dev_ok;
        logic div_done;
        logic need_mod;
        logic idx_last;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/core/pdst_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pdst_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pdst_pkg::DIV_W-1:0] i_dividend,
    input  logic [pdst_pkg::DVS_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pdst_pkg::DIV_W-1:0] o_quotient,
    output logic [pdst_pkg::DVS_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(pdst_pkg::DIV_W + 1);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [pdst_pkg::DIV_W-1:0] r_dvd;
    logic [pdst_pkg::DVS_W-1:0] r_dvs;
    logic [pdst_pkg::DVS_W-1:0] r_rem;

    logic [pdst_pkg::DVS_W:0]   rem_sh;
    logic [pdst_pkg::DVS_W:0]   rem_sub;
    logic                       ge;

    // shift in next dividend bit and trial subtract
    always_comb begin
        rem_sh  = {r_rem, r_dvd[pdst_pkg::DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        ge      = (rem_sh >= {1'b0, r_dvs});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(pdst_pkg::DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // quotient shifts into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[pdst_pkg::DVS_W-1:0] : rem_sh[pdst_pkg::DVS_W-1:0];
            r_dvd <= {r_dvd[pdst_pkg::DIV_W-2:0], ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_dvd;
    assign o_remainder = r_rem;

endmodule

FILE: rtl/core/pdst_dp.sv
// datapath: device state memory, update logic, divider and result register
`timescale 1ns / 1ps

module pdst_dp #(
    parameter int NUM_DEVICES = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pdst_pkg::t_cmd                  i_cmd,
    output pdst_pkg::t_stat                 o_stat,
    input  logic [pdst_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic [pdst_pkg::REQ_W-1:0]      i_in_user,
    input  logic                            i_cfg_wen,
    input  logic [pdst_pkg::SP_W-1:0]       i_cfg_wdata,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [pdst_pkg::OUT_DATA_W-1:0] o_out_data
);

    localparam int DEV_W = $clog2(NUM_DEVICES);
    localparam int EXT_W = (DEV_W > pdst_pkg::DEV_ID_W) ? DEV_W : pdst_pkg::DEV_ID_W;

    pdst_pkg::t_entry r_mem [NUM_DEVICES];
    pdst_pkg::t_entry r_rd_data;
    pdst_pkg::t_item  r_item;
    pdst_pkg::t_item  in_item;

    logic [pdst_pkg::SP_W-1:0] r_sched_period;
    logic [DEV_W-1:0]          r_idx;
    logic                      r_wake;
    logic                      r_out_valid;
    logic                      r_granted;
    logic                      r_bcast;
    logic [pdst_pkg::IFACE_W-1:0] r_egress;
    logic                      r_wake_out;

    logic [EXT_W-1:0]          in_dev_ext;
    logic [EXT_W-1:0]          item_dev_ext;
    logic [DEV_W-1:0]          in_idx;
    logic [DEV_W-1:0]          item_idx;
    logic                      item_dev_ok;
    logic                      iface_ok;
    logic                      grant;

    logic [pdst_pkg::DIV_W-1:0] phase_p1;
    logic [pdst_pkg::DIV_W-1:0] per_eff;
    logic [pdst_pkg::SP_W-1:0]  sp_eff;
    logic [pdst_pkg::DIV_W-1:0] div_dividend;
    logic [pdst_pkg::DVS_W-1:0] div_divisor;
    logic                       div_done;
    logic [pdst_pkg::DIV_W-1:0] div_quo;
    logic [pdst_pkg::DVS_W-1:0] div_rem;
    logic [pdst_pkg::TICKS_W-1:0] quo_ticks;

    pdst_pkg::t_entry item_entry;
    pdst_pkg::t_entry sweep_entry;
    pdst_pkg::t_entry wr_data;
    logic [DEV_W-1:0] wr_addr;
    logic [DEV_W-1:0] rd_addr;
    logic             wr_en;
    logic             rd_en;

    // unpack the input word
    always_comb begin
        in_item.req   = pdst_pkg::t_req'(i_in_user);
        in_item.dev   = i_in_data[7:0];
        in_item.iface = i_in_data[9:8];
        in_item.limit = i_in_data[17:10];
        in_item.plen  = i_in_data[33:18];
    end

    // device indexes and range checks
    always_comb begin
        in_dev_ext   = EXT_W'(in_item.dev);
        item_dev_ext = EXT_W'(r_item.dev);
        in_idx       = in_dev_ext[DEV_W-1:0];
        item_idx     = item_dev_ext[DEV_W-1:0];
        item_dev_ok  = (32'(r_item.dev) < 32'(NUM_DEVICES));
        iface_ok     = (32'(r_item.iface) < 32'(pdst_pkg::NUM_IFACES));
    end

    // scheduler period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sched_period <= pdst_pkg::SCHED_PERIOD_RST;
        end else if (i_cfg_wen) begin
            r_sched_period <= i_cfg_wdata;
        end
    end

    // latched request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= in_item;
        end
    end

    // sweep and clear index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // send, learn and set throttle update of the addressed entry
    always_comb begin
        grant      = item_dev_ok && (r_item.req == pdst_pkg::REQ_SEND) &&
                     ((r_rd_data.limit == '0) || (r_rd_data.count < r_rd_data.limit));
        quo_ticks  = (div_quo[pdst_pkg::TICKS_W-1:0] == '0) ? pdst_pkg::TICKS_W'(1)
                                                           : div_quo[pdst_pkg::TICKS_W-1:0];
        item_entry = r_rd_data;
        case (r_item.req)
            pdst_pkg::REQ_SEND: begin
                if (grant && (r_rd_data.count != pdst_pkg::COUNT_MAX)) begin
                    item_entry.count = r_rd_data.count + 1'b1;
                end
            end
            pdst_pkg::REQ_LEARN: begin
                if (iface_ok) begin
                    item_entry.route_valid = 1'b1;
                    item_entry.route_iface = r_item.iface;
                end
            end
            pdst_pkg::REQ_SET: begin
                item_entry.limit  = r_item.limit;
                item_entry.period = quo_ticks;
                item_entry.mark   = 1'b1;
            end
            default: begin
                item_entry = r_rd_data;
            end
        endcase
    end

    // tick update of one swept entry
    always_comb begin
        phase_p1    = {1'b0, r_rd_data.phase} + 1'b1;
        per_eff     = (r_rd_data.period == '0) ? pdst_pkg::DIV_W'(1)
                                               : {1'b0, r_rd_data.period};
        sweep_entry = r_rd_data;
        if (r_rd_data.mark) begin
            if (r_rd_data.phase == '0) begin
                sweep_entry.count = '0;
            end
            if (phase_p1 < per_eff) begin
                sweep_entry.phase = phase_p1[pdst_pkg::TICKS_W-1:0];
            end else if (phase_p1 == per_eff) begin
                sweep_entry.phase = '0;
            end else begin
                sweep_entry.phase = div_rem;
            end
        end
    end

    // divider operands: period over scheduler period, or phase wrap
    always_comb begin
        sp_eff = (r_sched_period == '0) ? pdst_pkg::SP_W'(1) : r_sched_period;
        if (i_cmd.div_mod) begin
            div_dividend = phase_p1;
            div_divisor  = per_eff[pdst_pkg::DVS_W-1:0];
        end else begin
            div_dividend = {1'b0, r_item.plen};
            div_divisor  = sp_eff;
        end
    end

    pdst_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // memory port selection
    always_comb begin
        rd_en   = i_cmd.rd_input || i_cmd.rd_sweep;
        rd_addr = i_cmd.rd_sweep ? r_idx : in_idx;
        wr_en   = i_cmd.wr_clear || i_cmd.wr_sweep ||
                  (i_cmd.wr_item && item_dev_ok && (r_item.req != pdst_pkg::REQ_TICK));
        wr_addr = (i_cmd.wr_clear || i_cmd.wr_sweep) ? r_idx : item_idx;
        if (i_cmd.wr_clear) begin
            wr_data = '0;
        end else if (i_cmd.wr_sweep) begin
            wr_data = sweep_entry;
        end else begin
            wr_data = item_entry;
        end
    end

    // device state memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // wake flag gathered over a sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.wake_clr) begin
            r_wake <= 1'b0;
        end else if (i_cmd.wr_sweep && r_rd_data.mark && (r_rd_data.phase == '0)) begin
            r_wake <= 1'b1;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_granted  <= grant;
            r_bcast    <= grant && !r_rd_data.route_valid;
            r_egress   <= (grant && r_rd_data.route_valid) ? r_rd_data.route_iface : '0;
            r_wake_out <= (r_item.req == pdst_pkg::REQ_TICK) && r_wake;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.req      = r_item.req;
        o_stat.dev_ok   = item_dev_ok;
        o_stat.div_done = div_done;
        o_stat.need_mod = r_rd_data.mark && (phase_p1 > per_eff);
        o_stat.idx_last = (r_idx == DEV_W'(NUM_DEVICES - 1));
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {3'b000, r_wake_out, r_egress, r_bcast, r_granted};

endmodule

FILE: rtl/core/pdst_ctrl.sv
// controller state machine: clearing pass, request sequencing and tick sweep
`timescale 1ns / 1ps

module pdst_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [pdst_pkg::REQ_W-1:0] i_in_req,
    input  pdst_pkg::t_stat            i_stat,
    output pdst_pkg::t_cmd             o_cmd
);

    pdst_pkg::t_state r_state;
    pdst_pkg::t_state n_state;
    logic             accept;

    assign o_in_ready = (r_state == pdst_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdst_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pdst_pkg::ST_CLEAR: begin
                if (i_stat.idx_last) n_state = pdst_pkg::ST_IDLE;
            end
            pdst_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (pdst_pkg::t_req'(i_in_req) == pdst_pkg::REQ_TICK)
                              ? pdst_pkg::ST_SW_RD : pdst_pkg::ST_EXEC;
                end
            end
            pdst_pkg::ST_EXEC: begin
                if ((i_stat.req == pdst_pkg::REQ_SET) && i_stat.dev_ok) begin
                    n_state = pdst_pkg::ST_DIV;
                end else if (i_stat.out_free) begin
                    n_state = pdst_pkg::ST_IDLE;
                end else begin
                    n_state = pdst_pkg::ST_DONE;
                end
            end
            pdst_pkg::ST_DIV: begin
                if (i_stat.div_done) n_state = pdst_pkg::ST_DONE;
            end
            pdst_pkg::ST_DONE: begin
                if (i_stat.out_free) n_state = pdst_pkg::ST_IDLE;
            end
            pdst_pkg::ST_SW_RD: begin
                n_state = pdst_pkg::ST_SW_EX;
            end
            pdst_pkg::ST_SW_EX: begin
                if (i_stat.need_mod) begin
                    n_state = pdst_pkg::ST_SW_DIV;
                end else begin
                    n_state = i_stat.idx_last ? pdst_pkg::ST_DONE : pdst_pkg::ST_SW_RD;
                end
            end
            pdst_pkg::ST_SW_DIV: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.idx_last ? pdst_pkg::ST_DONE : pdst_pkg::ST_SW_RD;
                end
            end
            default: begin
                n_state = pdst_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            pdst_pkg::ST_CLEAR: begin
                o_cmd.wr_clear = 1'b1;
                o_cmd.idx_inc  = !i_stat.idx_last;
                o_cmd.idx_clr  = i_stat.idx_last;
            end
            pdst_pkg::ST_IDLE: begin
                o_cmd.load_item = accept;
                o_cmd.rd_input  = accept;
                o_cmd.wake_clr  = accept;
            end
            pdst_pkg::ST_EXEC: begin
                if ((i_stat.req == pdst_pkg::REQ_SET) && i_stat.dev_ok) begin
                    o_cmd.div_start = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.wr_item = 1'b1;
                    o_cmd.push    = 1'b1;
                end
            end
            pdst_pkg::ST_DIV: begin
                o_cmd.div_mod = 1'b0;
            end
            pdst_pkg::ST_DONE: begin
                o_cmd.wr_item = i_stat.out_free;
                o_cmd.push    = i_stat.out_free;
            end
            pdst_pkg::ST_SW_RD: begin
                o_cmd.rd_sweep = 1'b1;
            end
            pdst_pkg::ST_SW_EX: begin
                o_cmd.div_mod = 1'b1;
                if (i_stat.need_mod) begin
                    o_cmd.div_start = 1'b1;
                end else begin
                    o_cmd.wr_sweep = 1'b1;
                    o_cmd.idx_inc  = !i_stat.idx_last;
                    o_cmd.idx_clr  = i_stat.idx_last;
                end
            end
            pdst_pkg::ST_SW_DIV: begin
                o_cmd.div_mod = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.wr_sweep = 1'b1;
                    o_cmd.idx_inc  = !i_stat.idx_last;
                    o_cmd.idx_clr  = i_stat.idx_last;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/per_device_send_throttle_top.sv
// top level of the per-device send throttle with learned egress routing
//
//  channel | direction | handshake             | payload
//  s_*     | in        | s_tvalid / s_tready   | s_tuser request kind, s_tdata request word
//  m_*     | out       | m_tvalid / m_tready   | m_tdata result word
//  cfg     | in        | i_cfg_wen             | i_cfg_wdata scheduler period
//
// send and learn do one memory read, then update, write-back and result.
// set throttle on a valid device also runs the 17-step serial divider before write-back.
// a tick sweeps every device entry, each through a read state and an update state,
// plus a divider run for each device whose phase lies beyond a shortened period.
// after reset a clearing pass over all NUM_DEVICES entries runs before s_tready rises.
// a stalled m_tready holds the finished word; one more request is taken meanwhile.
`timescale 1ns / 1ps

module per_device_send_throttle_top #(
    parameter int NUM_DEVICES = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // device[7:0], iface_index[9:8], burst_limit[17:10], period_len[33:18]
    input  logic [pdst_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [pdst_pkg::REQ_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // granted[0], broadcast[1], egress_iface[3:2], wake[4]
    output logic [pdst_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            i_cfg_wen,
    input  logic [pdst_pkg::SP_W-1:0]       i_cfg_wdata
);

    pdst_pkg::t_cmd  cmd;
    pdst_pkg::t_stat stat;

    // sequencing
    pdst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_in_req   (s_tuser),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // state memory and arithmetic
    pdst_dp #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_tdata),
        .i_in_user   (s_tuser),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_out_data  (m_tdata)
    );

endmodule
